// ===== hdl/apt_pkg.sv =====
// ----------------------------------------------------------------------------
// Affine point transform package
// Shared widths, command codes and lane control for the vertex transform unit.
// ----------------------------------------------------------------------------
package apt_pkg;

   localparam int LANES      = 3;
   localparam int ENTRIES    = 12;
   localparam int ENTRY_W    = 4;
   localparam int WORD_W     = 32;
   localparam int VEC_W      = WORD_W + 1;
   localparam int PROD_W     = WORD_W + VEC_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int T_BASE     = 9;
   localparam int CMD_W      = 3;
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = LANES * WORD_W;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [VEC_W-1:0]  vec_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD       = 3'd0,
      CMD_PT_GLOBAL  = 3'd1,
      CMD_PT_LOCAL   = 3'd2,
      CMD_VEC_GLOBAL = 3'd3,
      CMD_VEC_LOCAL  = 3'd4
   } cmd_type;

   typedef struct packed {
      logic prod_en;
      logic sum_en;
   } lane_ctl_type;

endpackage

// ===== hdl/apt_matrix.sv =====
// ----------------------------------------------------------------------------
// Affine point transform matrix store
// Twelve-entry column-major 3x4 matrix with operand selection for the lanes.
// ----------------------------------------------------------------------------
module apt_matrix import apt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [ENTRY_W-1:0] wr_index,
   input  word_type           wr_value,
   input  cmd_type            cmd,
   input  word_type           p_in  [LANES],
   output word_type           m_sel [LANES][LANES],
   output word_type           t_sel [LANES],
   output vec_type            p_sel [LANES]
);

   localparam logic [WORD_W-1:0] ONE = WORD_W'(1) << FRAC_BITS;

   word_type store_ff [ENTRIES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            store_ff[i] <= (i < T_BASE && (i % (LANES + 1)) == 0) ? ONE : '0;
         end
      end else if (wr_en && wr_index < ENTRY_W'(ENTRIES)) begin
         store_ff[wr_index] <= wr_value;
      end
   end

   // global direction uses the columns as given, local uses the transpose
   always_comb begin
      logic to_global;
      to_global = (cmd == CMD_PT_GLOBAL) || (cmd == CMD_VEC_GLOBAL);
      for (int r = 0; r < LANES; r++) begin
         for (int k = 0; k < LANES; k++) begin
            m_sel[r][k] = to_global ? store_ff[k*LANES + r] : store_ff[r*LANES + k];
         end
         t_sel[r] = (cmd == CMD_PT_GLOBAL) ? store_ff[T_BASE + r] : '0;
         p_sel[r] = (cmd == CMD_PT_LOCAL) ?
                    vec_type'(p_in[r]) - vec_type'(store_ff[T_BASE + r]) :
                    vec_type'(p_in[r]);
      end
   end

endmodule

// ===== hdl/apt_lane.sv =====
// ----------------------------------------------------------------------------
// Affine point transform lane
// One output row: three products, exact sum with translation, floor shift
// and saturation to 32 bits.
// ----------------------------------------------------------------------------
module apt_lane import apt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  lane_ctl_type ctl,
   input  word_type     m [LANES],
   input  vec_type      p [LANES],
   input  word_type     t,
   output word_type     result
);

   logic signed [PROD_W-1:0] prod_ff [LANES];
   logic signed [SUM_W-1:0]  tsc_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SUM_W-1:0]  shifted;
   logic [SUM_W-WORD_W:0]    upper;

   always_ff @(posedge clock) begin
      if (ctl.prod_en) begin
         for (int k = 0; k < LANES; k++) begin
            prod_ff[k] <= PROD_W'(m[k]) * PROD_W'(p[k]);
         end
         tsc_ff <= SUM_W'(t) <<< FRAC_BITS;
      end
      if (ctl.sum_en) begin
         sum_ff <= sum_in;
      end
   end

   always_comb begin
      sum_in = tsc_ff;
      for (int k = 0; k < LANES; k++) begin
         sum_in = sum_in + SUM_W'(prod_ff[k]);
      end
   end

   // arithmetic shift floors; clamp when the upper bits are not a sign run
   always_comb begin
      shifted = sum_ff >>> FRAC_BITS;
      upper   = shifted[SUM_W-1:WORD_W-1];
      if ((&upper) || !(|upper)) begin
         result = shifted[WORD_W-1:0];
      end else if (shifted[SUM_W-1]) begin
         result = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         result = {1'b0, {(WORD_W-1){1'b1}}};
      end
   end

endmodule

// ===== hdl/affine_point_transform.sv =====
// ----------------------------------------------------------------------------
// Affine point transform
// Vertex transform unit: 3x4 affine matrix, four point/vector mappings,
// three row lanes merged into one result beat.
//
//   channel  direction  tdata fields (low bit up)                   tuser
//   req_     in         entry_index, entry_value, in_x, in_y, in_z  cmd
//   rsp_     out        out_x, out_y, out_z                          -
//
// One beat per cycle unless the output stalls; a transform result is offered
// after it passes the input, operand, product, sum and output registers.
// Loads write the matrix as they leave the input stage, so later beats see
// them in order. Reset restores identity rotation and zero translation and
// holds req_tready low.
// A stalled output holds its stage; empty stages behind it keep filling.
// ----------------------------------------------------------------------------
module affine_point_transform import apt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // entry_index[3:0], entry_value[35:4], in_x[67:36], in_y[99:68],
   // in_z[131:100], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd[2:0]
   input  logic [CMD_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_x[31:0], out_y[63:32], out_z[95:64]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // stage ready chain
   logic rdy0, rdy1, rdy2, rdy3, rdy4;

   // input stage
   logic               s0_valid_ff;
   cmd_type            s0_cmd_ff;
   logic [ENTRY_W-1:0] s0_index_ff;
   word_type           s0_value_ff;
   word_type           s0_vec_ff [LANES];

   // operand stage
   logic     s1_valid_ff;
   logic     s1_valid_in;
   word_type s1_m_ff [LANES][LANES];
   word_type s1_t_ff [LANES];
   vec_type  s1_p_ff [LANES];

   logic s2_valid_ff;
   logic s3_valid_ff;
   logic rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   word_type     m_sel [LANES][LANES];
   word_type     t_sel [LANES];
   vec_type      p_sel [LANES];
   word_type     lane_result [LANES];
   lane_ctl_type lane_ctl;
   logic         s0_is_xform;
   logic         load_wr;

   assign rdy4 = !rsp_valid_ff || rsp_tready;
   assign rdy3 = !s3_valid_ff || rdy4;
   assign rdy2 = !s2_valid_ff || rdy3;
   assign rdy1 = !s1_valid_ff || rdy2;
   assign rdy0 = !s0_valid_ff || rdy1;

   assign req_tready = rdy0 && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign lane_ctl.prod_en = rdy2;
   assign lane_ctl.sum_en  = rdy3;

   always_comb begin
      unique case (s0_cmd_ff)
         CMD_PT_GLOBAL, CMD_PT_LOCAL, CMD_VEC_GLOBAL, CMD_VEC_LOCAL: begin
            s0_is_xform = 1'b1;
         end
         default: begin
            s0_is_xform = 1'b0;
         end
      endcase
   end

   // drop loads and unused codes here; loads commit as they leave
   assign s1_valid_in = s0_valid_ff && s0_is_xform;
   assign load_wr     = s0_valid_ff && rdy1 && (s0_cmd_ff == CMD_LOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy0) s0_valid_ff  <= req_tvalid;
         if (rdy1) s1_valid_ff  <= s1_valid_in;
         if (rdy2) s2_valid_ff  <= s1_valid_ff;
         if (rdy3) s3_valid_ff  <= s2_valid_ff;
         if (rdy4) rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy0) begin
         s0_cmd_ff    <= cmd_type'(req_tuser);
         s0_index_ff  <= req_tdata[ENTRY_W-1:0];
         s0_value_ff  <= req_tdata[ENTRY_W +: WORD_W];
         for (int k = 0; k < LANES; k++) begin
            s0_vec_ff[k] <= req_tdata[ENTRY_W + WORD_W*(k+1) +: WORD_W];
         end
      end
      if (rdy1) begin
         s1_m_ff <= m_sel;
         s1_t_ff <= t_sel;
         s1_p_ff <= p_sel;
      end
      if (rdy4) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   apt_matrix #(
      .FRAC_BITS (FRAC_BITS)
   ) u_matrix (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (load_wr),
      .wr_index (s0_index_ff),
      .wr_value (s0_value_ff),
      .cmd      (s0_cmd_ff),
      .p_in     (s0_vec_ff),
      .m_sel    (m_sel),
      .t_sel    (t_sel),
      .p_sel    (p_sel)
   );

   for (genvar r = 0; r < LANES; r++) begin : g_lane
      apt_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock  (clock),
         .ctl    (lane_ctl),
         .m      (s1_m_ff[r]),
         .p      (s1_p_ff),
         .t      (s1_t_ff[r]),
         .result (lane_result[r])
      );
   end

   // merge the three rows into one result beat
   always_comb begin
      for (int r = 0; r < LANES; r++) begin
         rsp_data_in[r*WORD_W +: WORD_W] = lane_result[r];
      end
   end

endmodule
